[hw/rtl/lcar_pkg.sv]
// shared constants and codes for the load cell converter reader
package lcar_pkg;

    localparam int DATA_BITS_DEF = 24;
    localparam int CNT_W         = 7;
    localparam int GAIN_W        = 2;
    localparam int KIND_W        = 2;
    localparam int READING_W     = 25;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WEIGH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TARE  = 2'd2;

    localparam logic REG_GAIN_PULSES  = 1'b0;
    localparam logic REG_SAMPLE_COUNT = 1'b1;

endpackage

[hw/rtl/lcar_div.sv]
// restoring divider, one quotient bit per cycle
module lcar_div
    import lcar_pkg::*;
#(
    parameter int SUM_W = DATA_BITS_DEF + CNT_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int ITER_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [SUM_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_sub;
    logic              fits;

    always_comb
    begin
        rem_shift = {rem_reg, q_reg[SUM_W-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        fits      = (rem_shift >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_W'(SUM_W);
            q_next    = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            q_next    = {q_reg[SUM_W-2:0], fits};
            rem_next  = fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < div_reg)
        else $error("divider remainder out of range");

endmodule

[hw/rtl/load_cell_adc_reader_unit.sv]
// load cell converter serial reader with averaging and tare
//
// each input transaction is one step: tuser carries the kind (tick, start
// weigh, start tare), tdata bit 0 the level of the converter data pin.
// each step gives exactly one output transaction with the serial clock
// level, busy and done flags and, on completion, the reading.
// a tick is one half period of the serial clock: wait for data low, then
// DATA_BITS clock pairs sampling after each falling edge, then gain_pulses
// extra pulses. words are flipped to offset binary and summed.
// a step's result is registered at the accepting edge; with the receiver
// ready and no divide running a step is taken every cycle. the step that
// finishes a sequence starts the restoring divider: its result is
// registered when the divider is done, and the input is not ready while
// the divider runs. a weigh reports mean minus tare offset, a tare stores
// the mean as the offset and reports it.
// reset clears all state: idle, clock low, offset zero, gain_pulses 1,
// sample_count 1. when the receiver stalls the result holds in the output
// register and no new step is accepted until it is taken.
// registers: gain_pulses at 0x0, sample_count at 0x4 (0 acts as 1).
module load_cell_adc_reader_unit
    import lcar_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // data_level
    input  logic [KIND_W-1:0]     s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // sck_level, busy_res, done_res, reading
    output logic [0:0]            m_tuser,   // reading_is_tare
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SUM_W     = DATA_BITS + CNT_W;
    localparam int BIT_CNT_W = $clog2(DATA_BITS + 1);
    localparam int EXT_W     = (DATA_BITS > READING_W) ? DATA_BITS : READING_W;
    localparam int PAD_W     = M_TDATA_W - READING_W - 3;
    localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_BIT_HIGH,
        PH_BIT_LOW,
        PH_GAIN_HIGH,
        PH_GAIN_LOW
    } phase_t;

    typedef enum logic {
        ENG_STEP,
        ENG_DIV
    } eng_t;

    eng_t                   eng_reg, eng_next;
    phase_t                 phase_reg, phase_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [GAIN_W-1:0]      pulse_cnt_reg, pulse_cnt_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [DATA_BITS-1:0]   offset_reg, offset_next;
    logic                   tare_reg, tare_next;
    logic                   sck_reg, sck_next;
    logic [GAIN_W-1:0]      gain_reg, gain_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic                   m_user_reg, m_user_next;

    logic                   accept;
    logic                   cfg_write;
    logic [KIND_W-1:0]      kind;
    logic                   data_level;
    logic                   word_done;
    logic [DATA_BITS-1:0]   word_value;
    logic [CNT_W-1:0]       left_dec;
    logic                   finishing;
    logic                   div_done;
    logic [SUM_W-1:0]       div_q;
    logic [DATA_BITS-1:0]   mean;
    logic [EXT_W-1:0]       diff;
    logic [READING_W-1:0]   reading;

    assign kind       = s_tuser;
    assign data_level = s_tdata[0];
    assign s_tready   = (eng_reg == ENG_STEP) && (!m_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_GAIN_PULSES:  prdata = APB_DATA_W'(gain_reg);
            REG_SAMPLE_COUNT: prdata = APB_DATA_W'(count_reg);
            default:          prdata = '0;
        endcase
    end

    lcar_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && finishing),
        .dividend (sum_next),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mean    = div_q[DATA_BITS-1:0];
    assign diff    = EXT_W'(mean) - EXT_W'(offset_reg);
    assign reading = READING_W'(tare_reg ? EXT_W'(mean) : diff);

    // serial sequencer, one step per accepted transaction
    always_comb
    begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        pulse_cnt_next = pulse_cnt_reg;
        shift_next     = shift_reg;
        sum_next       = sum_reg;
        left_next      = left_reg;
        total_next     = total_reg;
        tare_next      = tare_reg;
        sck_next       = sck_reg;
        word_done      = 1'b0;
        if (kind == KIND_WEIGH || kind == KIND_TARE)
        begin
            if (phase_reg == PH_IDLE)
            begin
                left_next      = (count_reg == '0) ? CNT_W'(1) : count_reg;
                total_next     = (count_reg == '0) ? CNT_W'(1) : count_reg;
                sum_next       = '0;
                shift_next     = '0;
                bit_cnt_next   = '0;
                pulse_cnt_next = '0;
                tare_next      = (kind == KIND_TARE);
                sck_next       = 1'b0;
                phase_next     = PH_WAIT;
            end
        end
        else if (kind == KIND_TICK)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (!data_level)
                    begin
                        shift_next   = '0;
                        bit_cnt_next = '0;
                        sck_next     = 1'b1;
                        phase_next   = PH_BIT_HIGH;
                    end
                end
                PH_BIT_HIGH:
                begin
                    sck_next   = 1'b0;
                    phase_next = PH_BIT_LOW;
                end
                PH_BIT_LOW:
                begin
                    shift_next   = {shift_reg[DATA_BITS-2:0], data_level};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg != BIT_CNT_W'(DATA_BITS - 1))
                    begin
                        sck_next   = 1'b1;
                        phase_next = PH_BIT_HIGH;
                    end
                    else if (gain_reg != '0)
                    begin
                        pulse_cnt_next = GAIN_W'(1);
                        sck_next       = 1'b1;
                        phase_next     = PH_GAIN_HIGH;
                    end
                    else
                    begin
                        word_done = 1'b1;
                    end
                end
                PH_GAIN_HIGH:
                begin
                    sck_next   = 1'b0;
                    phase_next = PH_GAIN_LOW;
                end
                PH_GAIN_LOW:
                begin
                    if (pulse_cnt_reg < gain_reg)
                    begin
                        pulse_cnt_next = pulse_cnt_reg + 1'b1;
                        sck_next       = 1'b1;
                        phase_next     = PH_GAIN_HIGH;
                    end
                    else
                    begin
                        word_done = 1'b1;
                    end
                end
                default:
                begin
                    sck_next   = 1'b0;
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // word complete: accumulate and either wait for the next or finish
        word_value = shift_next ^ TOP_BIT;
        left_dec   = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
        finishing  = 1'b0;
        if (word_done)
        begin
            sum_next  = sum_reg + SUM_W'(word_value);
            left_next = left_dec;
            if (left_dec != '0)
            begin
                phase_next = PH_WAIT;
            end
            else
            begin
                phase_next = PH_IDLE;
                finishing  = 1'b1;
            end
        end
    end

    // engine, result register and configuration
    always_comb
    begin
        eng_next     = eng_reg;
        offset_next  = offset_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        gain_next    = gain_reg;
        count_next   = count_reg;
        unique case (eng_reg)
            ENG_STEP:
            begin
                if (accept)
                begin
                    if (finishing)
                    begin
                        eng_next = ENG_DIV;
                    end
                    else
                    begin
                        m_valid_next = 1'b1;
                        m_data_next  = {PAD_W'(0), READING_W'(0), 1'b0,
                                        phase_next != PH_IDLE, sck_next};
                        m_user_next  = 1'b0;
                    end
                end
            end
            ENG_DIV:
            begin
                if (div_done)
                begin
                    eng_next     = ENG_STEP;
                    m_valid_next = 1'b1;
                    m_data_next  = {PAD_W'(0), reading, 1'b1, 1'b0, sck_reg};
                    m_user_next  = tare_reg;
                    if (tare_reg)
                    begin
                        offset_next = mean;
                    end
                end
            end
            default:
            begin
                eng_next = ENG_STEP;
            end
        endcase
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_GAIN_PULSES:  gain_next  = pwdata[GAIN_W-1:0];
                REG_SAMPLE_COUNT: count_next = pwdata[CNT_W-1:0];
                default:          gain_next  = gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg       <= ENG_STEP;
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= '0;
            pulse_cnt_reg <= '0;
            shift_reg     <= '0;
            sum_reg       <= '0;
            left_reg      <= '0;
            total_reg     <= '0;
            offset_reg    <= '0;
            tare_reg      <= 1'b0;
            sck_reg       <= 1'b0;
            gain_reg      <= GAIN_W'(1);
            count_reg     <= CNT_W'(1);
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_user_reg    <= 1'b0;
        end
        else
        begin
            eng_reg     <= eng_next;
            offset_reg  <= offset_next;
            gain_reg    <= gain_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_user_reg  <= m_user_next;
            if (accept)
            begin
                phase_reg     <= phase_next;
                bit_cnt_reg   <= bit_cnt_next;
                pulse_cnt_reg <= pulse_cnt_next;
                shift_reg     <= shift_next;
                sum_reg       <= sum_next;
                left_reg      <= left_next;
                total_reg     <= total_next;
                tare_reg      <= tare_next;
                sck_reg       <= sck_next;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> eng_reg == ENG_DIV)
        else $error("divider result outside divide state");

    a_finish_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        accept && finishing |=> eng_reg == ENG_DIV && !m_valid_reg)
        else $error("finishing step did not start the divide");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_data_reg[2] |-> !m_data_reg[1] && phase_reg == PH_IDLE)
        else $error("completed transaction still busy");

    a_idle_clock_low: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> !sck_reg)
        else $error("serial clock high while idle");

endmodule
